// ===== src/chxy_pkg.sv =====
`default_nettype none

package chxy_pkg;

   localparam int ROTATION_STEPS_DEF      = 16;
   localparam int ANGLE_FRACTION_BITS_DEF = 16;

   localparam int TABLE_FRACTION_BITS = 24;
   localparam int TABLE_SIZE          = 24;

   // Compass points in whole degrees.
   localparam logic [8:0] HEADING_EAST  = 9'd0;
   localparam logic [8:0] HEADING_NORTH = 9'd90;
   localparam logic [8:0] HEADING_WEST  = 9'd180;
   localparam logic [8:0] HEADING_SOUTH = 9'd270;
   localparam int         QUARTER_TURN  = 90;
   localparam int         FULL_TURN     = 360;

   typedef logic [29:0] atan_q24_type;

   // atan(2^-i) in degrees with 24 fractional bits.
   localparam atan_q24_type ATAN_DEG_Q24 [0:TABLE_SIZE-1] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
      30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
      30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
      30'd234684,    30'd117342,    30'd58671,     30'd29335,
      30'd14668,     30'd7334,      30'd3667,      30'd1833,
      30'd917,       30'd458,       30'd229,       30'd115
   };

   // Arctangent step i rounded half up to fbits fractional bits; zero past the table.
   function automatic logic [30:0] atan_entry(input int idx, input int fbits);
      int          sh;
      logic [31:0] t;
      sh = TABLE_FRACTION_BITS - fbits;
      if (idx >= TABLE_SIZE) begin
         return '0;
      end
      t = {2'b00, ATAN_DEG_Q24[5'(idx)]};
      if (sh == 0) begin
         return t[30:0];
      end
      t = (t + (32'd1 << (sh - 1))) >> sh;
      return t[30:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/compass_heading_from_xy.sv =====
// Channel  | Direction | Handshake           | Word
// req      | in        | req_valid/req_stall | x_low, x_high, y_low, y_high
// rsp      | out       | rsp_valid/rsp_stall | heading_deg
//
// One word is taken every cycle while req_stall is low; a heading passes through
// one register for assembly and quadrant fold, one per CORDIC rotation, and one
// output register for truncation and wrap.
// Reset clears the valid bits of every stage and of the output register.
// While a result waits under rsp_stall the whole pipeline holds and req_stall is high.

`default_nettype none

module compass_heading_from_xy
   import chxy_pkg::*;
#(
   parameter int ROTATION_STEPS      = ROTATION_STEPS_DEF,
   parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_x_low,
   input  wire logic [7:0] req_x_high,
   input  wire logic [7:0] req_y_low,
   input  wire logic [7:0] req_y_high,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [8:0]      rsp_heading_deg
);

   localparam int N  = ROTATION_STEPS;
   localparam int F  = ANGLE_FRACTION_BITS;
   localparam int W  = 16 + F + 3;
   localparam int ZW = F + 10;

   localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(QUARTER_TURN) <<< F;

   logic                 adv;
   logic                 vld_ff   [0:N];
   logic                 vld_in   [0:N];
   logic signed [W-1:0]  x_ff     [0:N];
   logic signed [W-1:0]  x_in     [0:N];
   logic signed [W-1:0]  y_ff     [0:N];
   logic signed [W-1:0]  y_in     [0:N];
   logic signed [ZW-1:0] z_ff     [0:N];
   logic signed [ZW-1:0] z_in     [0:N];
   logic                 spec_ff  [0:N];
   logic                 spec_in;
   logic [8:0]           sval_ff  [0:N];
   logic [8:0]           sval_in;

   logic signed [15:0]   xr;
   logic signed [15:0]   yr;
   logic signed [W-1:0]  xs;
   logic signed [W-1:0]  ys;

   logic signed [9:0]    whole;
   logic signed [9:0]    wrapped;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [8:0]           rsp_heading_ff;
   logic [8:0]           rsp_heading_in;

   // Every stage moves together unless the output word is held.
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Stage 0: assemble, catch the axis cases, fold the left half plane.
   always_comb begin
      xr = signed'({req_x_high, req_x_low});
      yr = signed'({req_y_high, req_y_low});
      xs = W'(xr) <<< F;
      ys = W'(yr) <<< F;

      vld_in[0] = req_valid;
      spec_in   = (yr == 16'sd0) || (xr == 16'sd0);
      if (yr == 16'sd0) begin
         sval_in = xr[15] ? HEADING_WEST : HEADING_EAST;
      end else if (yr[15]) begin
         sval_in = HEADING_SOUTH;
      end else begin
         sval_in = HEADING_NORTH;
      end

      x_in[0] = xs;
      y_in[0] = ys;
      z_in[0] = '0;
      if (xr[15]) begin
         if (!yr[15]) begin
            x_in[0] = ys;
            y_in[0] = -xs;
            z_in[0] = Z_QUARTER;
         end else begin
            x_in[0] = -ys;
            y_in[0] = xs;
            z_in[0] = -Z_QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= x_in[0];
         y_ff[0]    <= y_in[0];
         z_ff[0]    <= z_in[0];
         spec_ff[0] <= spec_in;
         sval_ff[0] <= sval_in;
      end
   end

   genvar s;
   generate
      for (s = 0; s < N; s++) begin : g_rot
         localparam logic signed [ZW-1:0] ATAN_S = ZW'(atan_entry(s, F));

         // Arithmetic shifts give the floor of the scaled coordinates.
         always_comb begin
            vld_in[s+1] = vld_ff[s];
            if (!y_ff[s][W-1]) begin
               x_in[s+1] = x_ff[s] + (y_ff[s] >>> s);
               y_in[s+1] = y_ff[s] - (x_ff[s] >>> s);
               z_in[s+1] = z_ff[s] + ATAN_S;
            end else begin
               x_in[s+1] = x_ff[s] - (y_ff[s] >>> s);
               y_in[s+1] = y_ff[s] + (x_ff[s] >>> s);
               z_in[s+1] = z_ff[s] - ATAN_S;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               x_ff[s+1]    <= x_in[s+1];
               y_ff[s+1]    <= y_in[s+1];
               z_ff[s+1]    <= z_in[s+1];
               spec_ff[s+1] <= spec_ff[s];
               sval_ff[s+1] <= sval_ff[s];
            end
         end
      end

      for (s = 0; s <= N; s++) begin : g_vld
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (adv) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   endgenerate

   // Truncate toward zero: a negative angle with a fraction rounds up by one.
   always_comb begin
      whole = $signed(z_ff[N][ZW-1:F]) +
              $signed({9'd0, z_ff[N][ZW-1] && (|z_ff[N][F-1:0])});
      wrapped = whole[9] ? whole + 10'(FULL_TURN) : whole;
      rsp_valid_in   = vld_ff[N];
      rsp_heading_in = spec_ff[N] ? sval_ff[N] : wrapped[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_heading_ff <= rsp_heading_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heading_deg = rsp_heading_ff;

endmodule

`default_nettype wire

// ===== src/chxy_checker.sv =====
`default_nettype none

module chxy_checker
   import chxy_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [8:0] rsp_heading_deg
);

   // A heading is always a whole degree below a full turn.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_deg < 9'(FULL_TURN)))
      else $error("heading out of range");

   // The input side only waits behind a held output word.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held output word");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid after reset");

   // A held output word stays valid and unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_heading_deg)))
      else $error("held output word changed");

endmodule

bind compass_heading_from_xy chxy_checker u_chxy_checker (.*);

`default_nettype wire
